// File: rtl/tfm_pkg.sv
// Package for the topic filter matcher: shared widths, register indexes,
// character codes and the state and filter bundles. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tfm_pkg;

  // Default filter capacity in bytes
  localparam int FILTER_BYTES_DEF = 32;

  // Filter position and length width (fixed by the 6-bit length register)
  localparam int POS_W = 6;
  // Positions reachable by a 6-bit index; bytes past the filter read as zero
  localparam int PAD_BYTES = 2 ** POS_W;

  localparam int BYTE_W     = 8;
  localparam int WORD_BYTES = 8;
  localparam int CFG_DATA_W = BYTE_W * WORD_BYTES;
  localparam int CFG_IDX_W  = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILTER_LENGTH = 3'd0,
    REG_FILTER_WORD_0 = 3'd1,
    REG_FILTER_WORD_1 = 3'd2,
    REG_FILTER_WORD_2 = 3'd3,
    REG_FILTER_WORD_3 = 3'd4
  } cfg_reg_e;

  // Topic and filter characters with a meaning
  localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_HASH  = 8'h23;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;

  // Filter bytes padded to every reachable position
  typedef logic [PAD_BYTES-1:0][BYTE_W-1:0] fbytes_t;

  // Effective filter as seen by the matcher
  typedef struct packed {
    logic [POS_W-1:0] len;
    fbytes_t          bytes;
  } tfm_filter_t;

  // Per-topic match state
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic             skip;
    logic             known;
    logic             value;
  } tfm_state_t;

endpackage

`default_nettype wire

// File: rtl/tfm_cfg_regs.sv
// Configuration registers of the topic filter matcher: filter length and
// filter bytes, presented as a zero-padded byte vector. Depends on tfm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfm_cfg_regs #(
  parameter int FILTER_BYTES = tfm_pkg::FILTER_BYTES_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [tfm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [tfm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output tfm_pkg::tfm_filter_t                  filter_o
);

  localparam logic [tfm_pkg::POS_W-1:0] FB_POS = tfm_pkg::POS_W'(FILTER_BYTES);

  logic [tfm_pkg::POS_W-1:0]                    len_q;
  logic [FILTER_BYTES-1:0][tfm_pkg::BYTE_W-1:0] bytes_q;
  logic [tfm_pkg::POS_W-1:0]                    eff_len;

  // Length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (cfg_we_i && cfg_index_i == tfm_pkg::REG_FILTER_LENGTH) begin
      len_q <= cfg_data_i[tfm_pkg::POS_W-1:0];
    end
  end

  // Filter bytes, each taken from its word register lane
  for (genvar k = 0; k < FILTER_BYTES; k++) begin : g_byte
    localparam int Word = k / tfm_pkg::WORD_BYTES;
    localparam int Lane = (k % tfm_pkg::WORD_BYTES) * tfm_pkg::BYTE_W;
    localparam logic [tfm_pkg::CFG_IDX_W-1:0] Idx =
      tfm_pkg::CFG_IDX_W'(int'(tfm_pkg::REG_FILTER_WORD_0) + Word);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        bytes_q[k] <= '0;
      end else if (cfg_we_i && cfg_index_i == Idx) begin
        bytes_q[k] <= cfg_data_i[Lane +: tfm_pkg::BYTE_W];
      end
    end
  end

  // Clamp the length to the storage
  assign eff_len      = (len_q > FB_POS) ? FB_POS : len_q;
  assign filter_o.len = eff_len;

  // Zero every position at or past the effective length
  for (genvar k = 0; k < tfm_pkg::PAD_BYTES; k++) begin : g_pad
    if (k < FILTER_BYTES) begin : g_stored
      assign filter_o.bytes[k] = (tfm_pkg::POS_W'(k) < eff_len) ? bytes_q[k] : '0;
    end else begin : g_empty
      assign filter_o.bytes[k] = '0;
    end
  end

endmodule

`default_nettype wire

// File: rtl/tfm_step.sv
// Next-state logic of the topic filter matcher for one topic byte,
// including the run of empty '+' levels at a '/'. Depends on tfm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tfm_step (
  input  wire tfm_pkg::tfm_filter_t         filter_i,
  input  wire tfm_pkg::tfm_state_t          state_i,
  input  wire logic [tfm_pkg::BYTE_W-1:0]   topic_byte_i,
  input  wire logic                         last_byte_i,
  output tfm_pkg::tfm_state_t               state_o,
  output logic                              matched_o
);

  logic [tfm_pkg::PAD_BYTES-1:0] plus_mask;
  logic [tfm_pkg::PAD_BYTES-1:0] plus_run;
  logic [tfm_pkg::POS_W-1:0]     run_len;
  logic [tfm_pkg::POS_W-1:0]     q;
  logic [tfm_pkg::POS_W:0]       q_ext;
  logic [tfm_pkg::POS_W:0]       s_ext;
  logic [tfm_pkg::BYTE_W-1:0]    c0;
  logic [tfm_pkg::BYTE_W-1:0]    c1;
  logic [tfm_pkg::BYTE_W-1:0]    c2;
  logic                          is_slash;
  tfm_pkg::tfm_state_t           nxt;

  // Mark filter '+' bytes
  always_comb begin
    for (int k = 0; k < tfm_pkg::PAD_BYTES; k++) begin
      plus_mask[k] = (filter_i.bytes[k] == tfm_pkg::CH_PLUS);
    end
  end

  // Count the '+' run that starts at the current position
  assign plus_run = ~(plus_mask >> state_i.pos);

  always_comb begin
    run_len = '0;
    for (int k = tfm_pkg::PAD_BYTES - 1; k >= 0; k--) begin
      if (plus_run[k]) begin
        run_len = tfm_pkg::POS_W'(k);
      end
    end
  end

  // A '/' passes over empty '+' levels before it is compared
  assign is_slash = (topic_byte_i == tfm_pkg::CH_SLASH);
  assign q        = is_slash ? state_i.pos + run_len : state_i.pos;
  assign q_ext    = {1'b0, q};
  assign s_ext    = {1'b0, filter_i.len};
  assign c0       = filter_i.bytes[q];
  assign c1       = filter_i.bytes[q + tfm_pkg::POS_W'(1)];
  assign c2       = filter_i.bytes[q + tfm_pkg::POS_W'(2)];

  // Advance the state or settle the verdict
  always_comb begin
    nxt = state_i;
    if (!state_i.known) begin
      if (state_i.skip && !is_slash) begin
        // Inside a '+' level: consume the byte
        if (last_byte_i) begin
          nxt.known = 1'b1;
          nxt.value = (state_i.pos == filter_i.len);
        end
      end else begin
        nxt.skip = 1'b0;
        nxt.pos  = q;
        if (q >= filter_i.len) begin
          nxt.known = 1'b1;
          nxt.value = 1'b0;
        end else if (c0 == topic_byte_i) begin
          if (last_byte_i && q_ext + 7'd3 == s_ext && c1 == tfm_pkg::CH_SLASH &&
              c2 == tfm_pkg::CH_HASH) begin
            // Trailing "/#" also matches the parent level
            nxt.known = 1'b1;
            nxt.value = 1'b1;
          end else begin
            nxt.pos = q + tfm_pkg::POS_W'(1);
            if (last_byte_i) begin
              nxt.known = 1'b1;
              nxt.value = (q_ext + 7'd1 == s_ext) ||
                          (q_ext + 7'd2 == s_ext && c1 == tfm_pkg::CH_PLUS);
            end
          end
        end else if (c0 == tfm_pkg::CH_PLUS) begin
          // Start of a '+' level
          nxt.pos  = q + tfm_pkg::POS_W'(1);
          nxt.skip = 1'b1;
          if (last_byte_i) begin
            nxt.known = 1'b1;
            nxt.value = (q_ext + 7'd1 == s_ext);
          end
        end else if (c0 == tfm_pkg::CH_HASH) begin
          nxt.known = 1'b1;
          nxt.value = (q_ext + 7'd1 == s_ext);
        end else begin
          nxt.known = 1'b1;
          nxt.value = 1'b0;
        end
      end
    end
    matched_o = nxt.known && nxt.value;
    // Rearm after the last byte of a topic
    if (last_byte_i) begin
      state_o = '0;
    end else begin
      state_o = nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/topic_filter_match.sv
// Top level of the topic filter matcher: input register, match state,
// result register. Depends on tfm_pkg, tfm_cfg_regs and tfm_step.
`timescale 1ns / 1ps
`default_nettype none

// Topic filter matcher. Topic bytes stream in one per item, last_byte_i
// marking the end of a topic; for each topic one result item carries matched_o.
// The block takes one topic byte every cycle while not stalled: each byte is
// held in an input register, compared against the filter combinationally
// (including any run of empty '+' levels at a '/'); the verdict of a last byte
// is registered in the output register as that byte retires. A waiting result
// only stalls the input when the next byte to finish is itself a last byte.
// Write the filter length and filter words only while no topic is in flight;
// a new topic may start in the cycle after a write.
module topic_filter_match #(
  parameter int FILTER_BYTES = tfm_pkg::FILTER_BYTES_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [tfm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [tfm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [tfm_pkg::BYTE_W-1:0]     topic_byte_i,
  input  wire logic                           last_byte_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                matched_o
);

  tfm_pkg::tfm_filter_t        filter;
  tfm_pkg::tfm_state_t         state_q;
  tfm_pkg::tfm_state_t         state_d;
  logic                        hold_valid_q;
  logic [tfm_pkg::BYTE_W-1:0]  hold_byte_q;
  logic                        hold_last_q;
  logic                        out_valid_q;
  logic                        matched_q;
  logic                        step_matched;
  logic                        advance;

  tfm_cfg_regs #(
    .FILTER_BYTES(FILTER_BYTES)
  ) u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .filter_o   (filter)
  );

  tfm_step u_step (
    .filter_i    (filter),
    .state_i     (state_q),
    .topic_byte_i(hold_byte_q),
    .last_byte_i (hold_last_q),
    .state_o     (state_d),
    .matched_o   (step_matched)
  );

  // Retire the held item unless its result has nowhere to go
  assign advance    = hold_valid_q && (!hold_last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !hold_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      hold_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      hold_byte_q <= topic_byte_i;
      hold_last_q <= last_byte_i;
    end
  end

  // Match state advances once per retired item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && hold_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && hold_last_q) begin
      matched_q <= step_matched;
    end
  end

  assign out_valid_o = out_valid_q;
  assign matched_o   = matched_q;

endmodule

`default_nettype wire
